/* src/srtf_pkg.sv */
// ============================================================================
// srtf_pkg - shared types and constants for the SRTF thread scheduler
// Holds field widths, function codes, slot and sequencer states, and the
// item / result / control structs passed between the scheduler modules.
// ============================================================================
package srtf_pkg;

    // Default sizing handed to the top level parameters
    localparam int SLOTS_DEF       = 4;
    localparam int BURST_PAIRS_DEF = 3;
    localparam int LEN_BITS_DEF    = 16;

    // Input item layout: six burst length fields of fixed width
    localparam int NUM_FIELDS = 6;
    localparam int FIELD_W    = 16;

    // Configuration register
    localparam int             CFG_W       = 8;
    localparam logic [CFG_W-1:0] IO_STEP_RST = 8'd3;

    // Function codes carried in the func field
    localparam logic [1:0] FUNC_CREATE = 2'd0;
    localparam logic [1:0] FUNC_CPU    = 2'd1;
    localparam logic [1:0] FUNC_SCHED  = 2'd2;

    // Per-slot thread status
    typedef enum logic [1:0] {
        SLOT_EMPTY,
        SLOT_READY,
        SLOT_RUNNING,
        SLOT_IO
    } srtf_slot_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL,
        ST_CPU_WB,
        ST_QSCAN,
        ST_REQUEUE,
        ST_PICK_RD,
        ST_PICK_CMP,
        ST_PICK_TAKE,
        ST_IO_SCAN,
        ST_IO_WB,
        ST_DONE
    } srtf_state_t;

    // One input item; len[0..5] = cpu1, io1, cpu2, io2, cpu3, io3
    typedef struct packed {
        logic [1:0]                        func;
        logic [NUM_FIELDS-1:0][FIELD_W-1:0] len;
    } srtf_item_t;

    // One result item
    typedef struct packed {
        logic [2:0] run_slot;
        logic [7:0] run_thread;
        logic [2:0] made_slot;
        logic       create_failed;
        logic [7:0] done_count;
    } srtf_result_t;

    // Sequencer handshake toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } srtf_ctrl_t;

endpackage

/* src/srtf_if.sv */
// ============================================================================
// srtf_if - channel interfaces of the SRTF thread scheduler
// Input item channel, result channel and configuration write channel, each
// a valid/ready transaction with source and sink modports.
// ============================================================================
interface srtf_in_if;
    import srtf_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic [FIELD_W-1:0] cpu1_len;
    logic [FIELD_W-1:0] io1_len;
    logic [FIELD_W-1:0] cpu2_len;
    logic [FIELD_W-1:0] io2_len;
    logic [FIELD_W-1:0] cpu3_len;
    logic [FIELD_W-1:0] io3_len;

    modport source (
        output valid, func, cpu1_len, io1_len, cpu2_len, io2_len, cpu3_len, io3_len,
        input  ready
    );
    modport sink (
        input  valid, func, cpu1_len, io1_len, cpu2_len, io2_len, cpu3_len, io3_len,
        output ready
    );
endinterface

interface srtf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] run_slot;
    logic [7:0] run_thread;
    logic [2:0] made_slot;
    logic       create_failed;
    logic [7:0] done_count;

    modport source (
        output valid, run_slot, run_thread, made_slot, create_failed, done_count,
        input  ready
    );
    modport sink (
        input  valid, run_slot, run_thread, made_slot, create_failed, done_count,
        output ready
    );
endinterface

interface srtf_cfg_if;
    import srtf_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;

    modport source (
        output valid, data,
        input  ready
    );
    modport sink (
        input  valid, data,
        output ready
    );
endinterface

/* src/srtf_alu.sv */
// ============================================================================
// srtf_alu - shared subtract / compare unit
// One subtractor serves burst decrement, IO step subtraction and the
// shortest-burst compare. Reports a - b and the a < b, a <= b flags.
// ============================================================================
module srtf_alu #(
    parameter int W = 16
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         lt,
    output logic         le
);

    logic [W:0] full;

    // Borrow out of the extended subtraction is the less-than flag
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[W-1:0];
    assign lt   = full[W];
    assign le   = full[W] | (full[W-1:0] == '0);

endmodule

/* src/srtf_ctrl.sv */
// ============================================================================
// srtf_ctrl - scheduler sequencer, slot state and burst store
// Walks each item through create fill, CPU decrement or the schedule pass
// (queue scan, requeue, shortest-burst pick, IO update) one step a cycle,
// sharing a single subtractor and one read / one write port of the store.
// ============================================================================
module srtf_ctrl #(
    parameter int SLOTS       = srtf_pkg::SLOTS_DEF,
    parameter int BURST_PAIRS = srtf_pkg::BURST_PAIRS_DEF,
    parameter int LEN_BITS    = srtf_pkg::LEN_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  srtf_pkg::srtf_item_t       item,
    input  logic [srtf_pkg::CFG_W-1:0] io_step,
    input  logic                       res_free,
    output srtf_pkg::srtf_ctrl_t       ctrl,
    output srtf_pkg::srtf_result_t     result
);
    import srtf_pkg::*;

    localparam int PHASES = 2 * BURST_PAIRS;
    localparam int DEPTH  = SLOTS * PHASES;
    localparam int SL_W   = $clog2(SLOTS);
    localparam int PH_W   = $clog2(PHASES);
    localparam int AD_W   = $clog2(DEPTH);
    localparam int QC_W   = $clog2(SLOTS + 1);
    localparam int MAXN   = (PHASES > SLOTS) ? PHASES : SLOTS;
    localparam int CNT_W  = $clog2(MAXN);
    localparam int ALU_W  = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;
    localparam int FS_W   = $clog2(NUM_FIELDS);

    // Store address of burst p of slot s
    function automatic logic [AD_W-1:0] mem_addr(input logic [SL_W-1:0] s,
                                                 input logic [PH_W-1:0] p);
        logic [31:0] a;
        a = 32'(s) * PHASES + 32'(p);
        return a[AD_W-1:0];
    endfunction

    // Sequencer and slot state
    srtf_state_t      state_reg, state_next;
    srtf_item_t       item_reg;
    srtf_slot_t       status_reg [SLOTS];
    logic [PH_W-1:0]  phase_reg  [SLOTS];
    logic [7:0]       thread_reg [SLOTS];
    logic [SL_W-1:0]  order_reg  [SLOTS];
    logic             inq_reg    [SLOTS];
    logic [QC_W-1:0]  qcnt_reg;
    logic             run_valid_reg;
    logic [SL_W-1:0]  run_idx_reg;
    logic [7:0]       created_reg;
    logic [7:0]       finished_reg;
    logic             made_valid_reg;
    logic [SL_W-1:0]  made_idx_reg;
    logic             fail_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [FS_W-1:0]  fsel_reg;
    logic [SL_W-1:0]  best_pos_reg;
    logic [LEN_BITS-1:0] best_len_reg;

    // Burst store
    logic [LEN_BITS-1:0] mem [DEPTH];
    logic [LEN_BITS-1:0] rd_data_reg;

    // Datapath nets
    logic                empty_found;
    logic [SL_W-1:0]     empty_idx;
    logic [SL_W-1:0]     scan_s;
    logic [SL_W-1:0]     take_s;
    logic [SL_W-1:0]     rd_slot;
    logic [SL_W-1:0]     wr_slot;
    logic [PH_W-1:0]     wr_phase;
    logic [AD_W-1:0]     rd_addr;
    logic [AD_W-1:0]     wr_addr;
    logic                mem_we;
    logic [LEN_BITS-1:0] mem_wdata;
    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W-1:0]    alu_diff;
    logic                alu_lt;
    logic                alu_le;
    logic                push_req;
    logic                push_ok;
    logic [SL_W-1:0]     push_slot;
    logic                done;
    logic                scan_end;
    logic                pick_end;
    logic                cpu_last;
    logic                io_last;
    logic                run_ok;

    // Shared subtractor
    srtf_alu #(.W(ALU_W)) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .diff (alu_diff),
        .lt   (alu_lt),
        .le   (alu_le)
    );

    // First empty slot, lowest index wins
    always_comb
    begin
        empty_found = 1'b0;
        empty_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (status_reg[i] == SLOT_EMPTY)
            begin
                empty_found = 1'b1;
                empty_idx   = SL_W'(i);
            end
        end
    end

    // Loop position and end-of-burst decodes
    assign scan_s   = cnt_reg[SL_W-1:0];
    assign take_s   = order_reg[best_pos_reg];
    assign scan_end = (cnt_reg == CNT_W'(SLOTS - 1));
    assign pick_end = ((32'(cnt_reg) + 32'd1) == 32'(qcnt_reg));
    assign cpu_last = (phase_reg[run_idx_reg] == PH_W'(PHASES - 1));
    assign io_last  = (phase_reg[scan_s] == PH_W'(PHASES - 1));
    assign run_ok   = run_valid_reg && (status_reg[run_idx_reg] == SLOT_RUNNING);
    assign rd_addr  = mem_addr(rd_slot, phase_reg[rd_slot]);
    assign wr_addr  = mem_addr(wr_slot, wr_phase);
    assign alu_a    = ALU_W'(rd_data_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                priority if (item_reg.func == FUNC_CREATE)
                    state_next = empty_found ? ST_FILL : ST_DONE;
                else if (item_reg.func == FUNC_CPU)
                    state_next = run_ok ? ST_CPU_WB : ST_DONE;
                else if (item_reg.func == FUNC_SCHED)
                    state_next = ST_QSCAN;
                else
                    state_next = ST_DONE;
            end
            ST_FILL:
            begin
                if (cnt_reg == CNT_W'(PHASES - 1))
                    state_next = ST_DONE;
            end
            ST_CPU_WB:
                state_next = ST_DONE;
            ST_QSCAN:
            begin
                if (scan_end)
                    state_next = ST_REQUEUE;
            end
            ST_REQUEUE:
                state_next = ((qcnt_reg != '0) || push_ok) ? ST_PICK_RD : ST_IO_SCAN;
            ST_PICK_RD:
                state_next = ST_PICK_CMP;
            ST_PICK_CMP:
                state_next = pick_end ? ST_PICK_TAKE : ST_PICK_RD;
            ST_PICK_TAKE:
                state_next = ST_IO_SCAN;
            ST_IO_SCAN:
            begin
                priority if (status_reg[scan_s] == SLOT_IO)
                    state_next = ST_IO_WB;
                else if (scan_end)
                    state_next = ST_DONE;
                else
                    state_next = ST_IO_SCAN;
            end
            ST_IO_WB:
                state_next = scan_end ? ST_DONE : ST_IO_SCAN;
            ST_DONE:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Store port, subtractor operand and queue push control per state
    always_comb
    begin
        rd_slot   = run_idx_reg;
        wr_slot   = run_idx_reg;
        wr_phase  = phase_reg[run_idx_reg];
        mem_we    = 1'b0;
        mem_wdata = '0;
        alu_b     = '0;
        push_req  = 1'b0;
        push_slot = scan_s;
        done      = 1'b0;
        unique case (state_reg)
            ST_FILL:
            begin
                mem_we    = 1'b1;
                wr_slot   = made_idx_reg;
                wr_phase  = cnt_reg[PH_W-1:0];
                mem_wdata = LEN_BITS'(item_reg.len[fsel_reg]);
            end
            ST_CPU_WB:
            begin
                alu_b     = ALU_W'(1);
                mem_we    = 1'b1;
                mem_wdata = alu_lt ? '0 : alu_diff[LEN_BITS-1:0];
            end
            ST_QSCAN:
                push_req = (status_reg[scan_s] == SLOT_READY) && !inq_reg[scan_s];
            ST_REQUEUE:
            begin
                push_req  = run_ok;
                push_slot = run_idx_reg;
            end
            ST_PICK_RD:
                rd_slot = order_reg[scan_s];
            ST_PICK_CMP:
                alu_b = ALU_W'(best_len_reg);
            ST_IO_SCAN:
                rd_slot = scan_s;
            ST_IO_WB:
            begin
                alu_b     = ALU_W'(io_step);
                mem_we    = 1'b1;
                wr_slot   = scan_s;
                wr_phase  = phase_reg[scan_s];
                mem_wdata = alu_le ? '0 : alu_diff[LEN_BITS-1:0];
                push_req  = alu_le && !io_last;
            end
            ST_DONE:
                done = res_free;
            default:
            begin
            end
        endcase
        push_ok = push_req && (qcnt_reg != QC_W'(SLOTS));
    end

    // Burst store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
            item_reg <= item;
        if ((state_reg == ST_PICK_CMP) && ((cnt_reg == '0) || alu_lt))
            best_len_reg <= rd_data_reg;
    end

    // Control and slot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_reg[i] <= SLOT_EMPTY;
                phase_reg[i]  <= '0;
                thread_reg[i] <= '0;
                order_reg[i]  <= '0;
                inq_reg[i]    <= 1'b0;
            end
            qcnt_reg       <= '0;
            run_valid_reg  <= 1'b0;
            run_idx_reg    <= '0;
            created_reg    <= '0;
            finished_reg   <= '0;
            made_valid_reg <= 1'b0;
            made_idx_reg   <= '0;
            fail_reg       <= 1'b0;
            cnt_reg        <= '0;
            fsel_reg       <= '0;
            best_pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        made_valid_reg <= 1'b0;
                        fail_reg       <= 1'b0;
                    end
                end
                ST_DECODE:
                begin
                    cnt_reg  <= '0;
                    fsel_reg <= '0;
                    if (item_reg.func == FUNC_CREATE)
                    begin
                        if (empty_found)
                        begin
                            made_valid_reg         <= 1'b1;
                            made_idx_reg           <= empty_idx;
                            created_reg            <= created_reg + 8'd1;
                            thread_reg[empty_idx]  <= created_reg + 8'd1;
                            phase_reg[empty_idx]   <= '0;
                            status_reg[empty_idx]  <= SLOT_READY;
                            inq_reg[empty_idx]     <= 1'b0;
                        end
                        else
                            fail_reg <= 1'b1;
                    end
                end
                ST_FILL:
                begin
                    cnt_reg  <= cnt_reg + 1'b1;
                    fsel_reg <= (fsel_reg == FS_W'(NUM_FIELDS - 1)) ? '0 : fsel_reg + 1'b1;
                end
                ST_CPU_WB:
                begin
                    // burst over: go to IO, or finish after the last burst
                    if (alu_le)
                    begin
                        run_valid_reg <= 1'b0;
                        if (cpu_last)
                        begin
                            status_reg[run_idx_reg] <= SLOT_EMPTY;
                            inq_reg[run_idx_reg]    <= 1'b0;
                            finished_reg            <= finished_reg + 8'd1;
                        end
                        else
                        begin
                            phase_reg[run_idx_reg]  <= phase_reg[run_idx_reg] + 1'b1;
                            status_reg[run_idx_reg] <= SLOT_IO;
                        end
                    end
                end
                ST_QSCAN:
                    cnt_reg <= cnt_reg + 1'b1;
                ST_REQUEUE:
                begin
                    if (run_ok)
                        status_reg[run_idx_reg] <= SLOT_READY;
                    run_valid_reg <= 1'b0;
                    cnt_reg       <= '0;
                    best_pos_reg  <= '0;
                end
                ST_PICK_CMP:
                begin
                    // strict less keeps the earliest position on ties
                    if ((cnt_reg == '0) || alu_lt)
                        best_pos_reg <= scan_s;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_PICK_TAKE:
                begin
                    for (int i = 0; i < SLOTS - 1; i++)
                    begin
                        if (SL_W'(i) >= best_pos_reg)
                            order_reg[i] <= order_reg[i + 1];
                    end
                    qcnt_reg           <= qcnt_reg - 1'b1;
                    inq_reg[take_s]    <= 1'b0;
                    status_reg[take_s] <= SLOT_RUNNING;
                    run_valid_reg      <= 1'b1;
                    run_idx_reg        <= take_s;
                    cnt_reg            <= '0;
                end
                ST_IO_SCAN:
                begin
                    if (status_reg[scan_s] != SLOT_IO)
                        cnt_reg <= cnt_reg + 1'b1;
                end
                ST_IO_WB:
                begin
                    if (alu_le)
                    begin
                        if (io_last)
                        begin
                            status_reg[scan_s] <= SLOT_EMPTY;
                            inq_reg[scan_s]    <= 1'b0;
                            finished_reg       <= finished_reg + 8'd1;
                        end
                        else
                        begin
                            phase_reg[scan_s]  <= phase_reg[scan_s] + 1'b1;
                            status_reg[scan_s] <= SLOT_READY;
                        end
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                begin
                end
            endcase

            // Append to the ready queue tail
            if (push_ok)
            begin
                order_reg[qcnt_reg[SL_W-1:0]] <= push_slot;
                qcnt_reg                      <= qcnt_reg + 1'b1;
                inq_reg[push_slot]            <= 1'b1;
            end
        end
    end

    // Result and handshake toward the top level
    assign ctrl.idle = (state_reg == ST_IDLE);
    assign ctrl.done = done;

    assign result.run_slot      = run_valid_reg ?
                                  3'({1'b0, run_idx_reg} + (SL_W + 1)'(1)) : 3'd0;
    assign result.run_thread    = run_valid_reg ? thread_reg[run_idx_reg] : 8'd0;
    assign result.made_slot     = made_valid_reg ?
                                  3'({1'b0, made_idx_reg} + (SL_W + 1)'(1)) : 3'd0;
    assign result.create_failed = fail_reg;
    assign result.done_count    = finished_reg;

    // Running slot is marked running and never sits in the ready queue
    a_run_status: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && run_valid_reg) |-> (status_reg[run_idx_reg] == SLOT_RUNNING))
        else $error("running slot not in running status");

    a_run_not_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && run_valid_reg) |-> !inq_reg[run_idx_reg])
        else $error("running slot still queued");

    // A pick always leaves a thread running
    a_pick_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PICK_TAKE) |=> run_valid_reg)
        else $error("pick did not start a thread");

    // Queue fill never exceeds the slot count
    a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (qcnt_reg <= QC_W'(SLOTS)))
        else $error("ready queue overflow");

endmodule

/* src/srtf_thread_scheduler.sv */
// ============================================================================
// srtf_thread_scheduler - preemptive shortest-remaining-time-first scheduler
// Top level: channel handshakes, io_step register, result register.
// ============================================================================
// One item is processed at a time; in_ch.ready is high only while the
// sequencer idles, and a finished result waits in an output register so the
// next item can be accepted before it is taken. All steps go through one
// subtractor and a single read / single write port on the burst store; a
// create writes the store once per burst. io_step is written on cfg and takes
// effect from the next IO update on; cfg.ready is always high.
module srtf_thread_scheduler #(
    parameter int SLOTS       = srtf_pkg::SLOTS_DEF,
    parameter int BURST_PAIRS = srtf_pkg::BURST_PAIRS_DEF,
    parameter int LEN_BITS    = srtf_pkg::LEN_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    srtf_in_if.sink    in_ch,
    srtf_out_if.source out_ch,
    srtf_cfg_if.sink   cfg
);
    import srtf_pkg::*;

    logic [CFG_W-1:0] io_step_reg;
    logic             out_valid_reg;
    srtf_result_t     out_data_reg;
    srtf_ctrl_t       ctrl;
    srtf_result_t     result;
    srtf_item_t       item;
    logic             start;
    logic             res_free;

    // Configuration register
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            io_step_reg <= IO_STEP_RST;
        else if (cfg.valid)
            io_step_reg <= cfg.data;
    end

    // Input transaction
    assign in_ch.ready = ctrl.idle;
    assign start       = in_ch.valid && ctrl.idle;

    always_comb
    begin
        item.func   = in_ch.func;
        item.len[0] = in_ch.cpu1_len;
        item.len[1] = in_ch.io1_len;
        item.len[2] = in_ch.cpu2_len;
        item.len[3] = in_ch.io2_len;
        item.len[4] = in_ch.cpu3_len;
        item.len[5] = in_ch.io3_len;
    end

    srtf_ctrl #(
        .SLOTS       (SLOTS),
        .BURST_PAIRS (BURST_PAIRS),
        .LEN_BITS    (LEN_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .io_step  (io_step_reg),
        .res_free (res_free),
        .ctrl     (ctrl),
        .result   (result)
    );

    // Output register
    assign res_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctrl.done)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
            out_data_reg <= result;
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.run_slot      = out_data_reg.run_slot;
    assign out_ch.run_thread    = out_data_reg.run_thread;
    assign out_ch.made_slot     = out_data_reg.made_slot;
    assign out_ch.create_failed = out_data_reg.create_failed;
    assign out_ch.done_count    = out_data_reg.done_count;

endmodule
